### rtl/esc_pkg.sv
package esc_pkg;

   localparam int unsigned AXES      = 3;
   localparam int unsigned VW        = 32;  // Q16.16 field width
   localparam int unsigned DW        = 33;  // exact difference width
   localparam int unsigned PW        = 66;  // signed product width
   localparam int unsigned NW        = 68;  // n2 and dot width
   localparam int unsigned QW        = 34;  // quotient width
   localparam int unsigned PPW       = 67;  // partial product width
   localparam int unsigned NUMW      = 101; // full numerator width
   localparam int unsigned SW        = 36;  // width of the sums before clipping
   localparam int unsigned ESC_LATENCY = 40; // accepting edge to result strobe cycle

   // item data that travels alongside the arithmetic
   typedef struct packed {
      logic [AXES-1:0][VW-1:0] v1;
      logic [AXES-1:0][VW-1:0] v2;
      logic [AXES-1:0]         qneg;
      logic                    coinc;
   } side_type;

   // divider state: shared denominator, partial remainders, and per axis a
   // register that shifts numerator bits out and quotient bits in
   typedef struct packed {
      logic [NW-1:0]             n2;
      logic [AXES-1:0][NW-1:0]   rem;
      logic [AXES-1:0][QW-1:0]   sh;
   } div_type;

endpackage

### rtl/esc_div_step.sv
module esc_div_step
   import esc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_in,
   input  div_type  div_in,
   input  side_type side_in,
   output logic     valid_ff,
   output div_type  div_ff,
   output side_type side_ff
);

   div_type div_in_n;

   // one restoring step on each axis
   always_comb begin
      logic [NW:0] trial;
      logic        ge;
      div_in_n    = div_in;
      for (int i = 0; i < AXES; i++) begin
         trial = {div_in.rem[i], div_in.sh[i][QW-1]};
         ge    = (trial >= {1'b0, div_in.n2});
         if (ge) begin
            trial = trial - {1'b0, div_in.n2};
         end
         div_in_n.rem[i] = trial[NW-1:0];
         div_in_n.sh[i]  = {div_in.sh[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      div_ff  <= div_in_n;
      side_ff <= side_in;
   end

endmodule

### rtl/elastic_sphere_collision.sv
// Equal-mass elastic sphere collision, fully pipelined.
// Stages in order: differences, products, sums, partial products, divider seed, divider, output register.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// The 34 stages of the restoring divider set the depth.
// Reset (synchronous, active high) drops every transaction in flight.
module elastic_sphere_collision
   import esc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_first_pos_x,
   input  logic signed [31:0] req_first_pos_y,
   input  logic signed [31:0] req_first_pos_z,
   input  logic signed [31:0] req_first_vel_x,
   input  logic signed [31:0] req_first_vel_y,
   input  logic signed [31:0] req_first_vel_z,
   input  logic signed [31:0] req_second_pos_x,
   input  logic signed [31:0] req_second_pos_y,
   input  logic signed [31:0] req_second_pos_z,
   input  logic signed [31:0] req_second_vel_x,
   input  logic signed [31:0] req_second_vel_y,
   input  logic signed [31:0] req_second_vel_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_first_vel_x,
   output logic signed [31:0] rsp_new_first_vel_y,
   output logic signed [31:0] rsp_new_first_vel_z,
   output logic signed [31:0] rsp_new_second_vel_x,
   output logic signed [31:0] rsp_new_second_vel_y,
   output logic signed [31:0] rsp_new_second_vel_z,
   output logic               rsp_coincident_centers,
   output logic               rsp_saturated
);

   // nothing ever holds the pipeline, so a transaction can enter every cycle
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   logic [AXES-1:0][VW-1:0] p1, p2, v1, v2;
   assign p1 = {req_first_pos_z,  req_first_pos_y,  req_first_pos_x};
   assign p2 = {req_second_pos_z, req_second_pos_y, req_second_pos_x};
   assign v1 = {req_first_vel_z,  req_first_vel_y,  req_first_vel_x};
   assign v2 = {req_second_vel_z, req_second_vel_y, req_second_vel_x};

   // ---------------- stage 1: exact differences ----------------
   logic                    s1_valid_ff;
   logic [AXES-1:0][DW-1:0] d1_ff, w1_ff, d1_in, w1_in;
   side_type                side1_ff, side1_in;

   always_comb begin
      side1_in       = '0;
      side1_in.v1    = v1;
      side1_in.v2    = v2;
      for (int i = 0; i < AXES; i++) begin
         d1_in[i] = {p1[i][VW-1], p1[i]} - {p2[i][VW-1], p2[i]};
         w1_in[i] = {v2[i][VW-1], v2[i]} - {v1[i][VW-1], v1[i]};
      end
   end

   // ---------------- stage 2: products ----------------
   logic                    s2_valid_ff;
   logic [AXES-1:0][PW-1:0] sq2_ff, wd2_ff, sq2_in, wd2_in;
   logic [AXES-1:0][DW-1:0] ad2_ff, ad2_in;
   side_type                side2_ff, side2_in;

   always_comb begin
      side2_in = side1_ff;
      for (int i = 0; i < AXES; i++) begin
         sq2_in[i] = $signed(d1_ff[i]) * $signed(d1_ff[i]);
         wd2_in[i] = $signed(w1_ff[i]) * $signed(d1_ff[i]);
         // magnitude of the difference stays below 2^32, so 33 bits hold it
         ad2_in[i] = d1_ff[i][DW-1] ? (~d1_ff[i] + 1'b1) : d1_ff[i];
         side2_in.qneg[i] = d1_ff[i][DW-1];
      end
   end

   // ---------------- stage 3: |d|^2 and (v2-v1).d ----------------
   logic                    s3_valid_ff;
   logic [NW-1:0]           n2_3_ff, dot3_ff, n2_3_in, dot3_in;
   logic [AXES-1:0][DW-1:0] ad3_ff;
   side_type                side3_ff;

   always_comb begin
      n2_3_in = '0;
      dot3_in = '0;
      for (int i = 0; i < AXES; i++) begin
         n2_3_in = n2_3_in + {{(NW-PW){sq2_ff[i][PW-1]}}, sq2_ff[i]};
         dot3_in = dot3_in + {{(NW-PW){wd2_ff[i][PW-1]}}, wd2_ff[i]};
      end
   end

   // ---------------- stage 4: partial products of |dot|.|d_i| ----------------
   logic                     s4_valid_ff;
   logic [AXES-1:0][PPW-1:0] pl4_ff, ph4_ff, pl4_in, ph4_in;
   logic [NW-1:0]            n2_4_ff;
   side_type                 side4_ff, side4_in;

   always_comb begin
      logic          dneg;
      logic [NW-1:0] dm;
      dneg     = dot3_ff[NW-1];
      dm       = dneg ? (~dot3_ff + 1'b1) : dot3_ff;
      side4_in = side3_ff;
      side4_in.coinc = (n2_3_ff == '0);
      for (int i = 0; i < AXES; i++) begin
         pl4_in[i] = PPW'(dm[QW-1:0]  * ad3_ff[i]);
         ph4_in[i] = PPW'(dm[NW-1:QW] * ad3_ff[i]);
         // flip the quotient sign where dot and d_i disagree
         side4_in.qneg[i] = side3_ff.qneg[i] ^ dneg;
      end
   end

   // ---------------- stage 5: full numerator, divider seed ----------------
   logic     div_vld [0:QW];
   div_type  div_st  [0:QW];
   side_type div_sd  [0:QW];
   div_type  div0_in;

   always_comb begin
      logic [NUMW-1:0] num;
      div0_in    = '0;
      div0_in.n2 = n2_4_ff;
      for (int i = 0; i < AXES; i++) begin
         num = {{(NUMW-PPW){1'b0}}, pl4_ff[i]} + {ph4_ff[i], {QW{1'b0}}};
         // the quotient fits in QW bits, so the top part is already below n2
         div0_in.rem[i] = {1'b0, num[NUMW-1:QW]};
         div0_in.sh[i]  = num[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         div_vld[0]  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         div_vld[0]  <= s4_valid_ff;
      end
      d1_ff    <= d1_in;
      w1_ff    <= w1_in;
      side1_ff <= side1_in;
      sq2_ff   <= sq2_in;
      wd2_ff   <= wd2_in;
      ad2_ff   <= ad2_in;
      side2_ff <= side2_in;
      n2_3_ff  <= n2_3_in;
      dot3_ff  <= dot3_in;
      ad3_ff   <= ad2_ff;
      side3_ff <= side2_ff;
      pl4_ff   <= pl4_in;
      ph4_ff   <= ph4_in;
      n2_4_ff  <= n2_3_ff;
      side4_ff <= side4_in;
      div_st[0] <= div0_in;
      div_sd[0] <= side4_ff;
   end

   // ---------------- divider: one quotient bit per stage ----------------
   for (genvar g = 0; g < QW; g++) begin : g_div
      esc_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .valid_in (div_vld[g]),
         .div_in   (div_st[g]),
         .side_in  (div_sd[g]),
         .valid_ff (div_vld[g+1]),
         .div_ff   (div_st[g+1]),
         .side_ff  (div_sd[g+1])
      );
   end

   // ---------------- output stage: apply, clip, register ----------------
   logic                    out_valid_ff;
   logic [2*AXES-1:0][VW-1:0] out_vel_ff, out_vel_in;
   logic                    out_coinc_ff, out_sat_ff, out_sat_in;

   always_comb begin
      side_type      sd;
      logic [SW-1:0] qs, r;
      logic          pos_ovf, neg_ovf;
      sd         = div_sd[QW];
      out_sat_in = 1'b0;
      out_vel_in = '0;
      for (int i = 0; i < 2*AXES; i++) begin
         if (i < AXES) begin
            qs = sd.qneg[i] ? -{2'b00, div_st[QW].sh[i]} : {2'b00, div_st[QW].sh[i]};
            r  = {{(SW-VW){sd.v1[i][VW-1]}}, sd.v1[i]} + qs;
         end else begin
            qs = sd.qneg[i-AXES] ? -{2'b00, div_st[QW].sh[i-AXES]}
                                 : {2'b00, div_st[QW].sh[i-AXES]};
            r  = {{(SW-VW){sd.v2[i-AXES][VW-1]}}, sd.v2[i-AXES]} - qs;
         end
         pos_ovf = ~r[SW-1] & (r[SW-2:VW-1] != '0);
         neg_ovf =  r[SW-1] & (r[SW-2:VW-1] != '1);
         // coincident centres: pass the velocities through untouched
         if (sd.coinc) begin
            out_vel_in[i] = (i < AXES) ? sd.v1[i] : sd.v2[i-AXES];
         end else if (pos_ovf) begin
            out_vel_in[i] = {1'b0, {(VW-1){1'b1}}};
            out_sat_in    = 1'b1;
         end else if (neg_ovf) begin
            out_vel_in[i] = {1'b1, {(VW-1){1'b0}}};
            out_sat_in    = 1'b1;
         end else begin
            out_vel_in[i] = r[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_vld[QW];
      end
      out_vel_ff   <= out_vel_in;
      out_coinc_ff <= div_sd[QW].coinc;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_new_first_vel_x    = out_vel_ff[0];
   assign rsp_new_first_vel_y    = out_vel_ff[1];
   assign rsp_new_first_vel_z    = out_vel_ff[2];
   assign rsp_new_second_vel_x   = out_vel_ff[3];
   assign rsp_new_second_vel_y   = out_vel_ff[4];
   assign rsp_new_second_vel_z   = out_vel_ff[5];
   assign rsp_coincident_centers = out_coinc_ff;
   assign rsp_saturated          = out_sat_ff;

endmodule

### rtl/esc_checker.sv
module esc_checker
   import esc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_first_vel_x,
   input logic        rsp_valid,
   input logic [31:0] rsp_new_first_vel_x,
   input logic        rsp_coincident_centers,
   input logic        rsp_saturated
);

   a_no_stall: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##ESC_LATENCY rsp_valid)
      else $error("transaction lost");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ESC_LATENCY))
      else $error("transaction invented");

   a_coinc_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coincident_centers) |-> !rsp_saturated)
      else $error("saturation on coincident centres");

   a_coinc_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coincident_centers) |->
         rsp_new_first_vel_x == $past(req_first_vel_x, ESC_LATENCY))
      else $error("coincident velocity altered");

endmodule

bind elastic_sphere_collision esc_checker u_esc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .req_first_vel_x        (req_first_vel_x),
   .rsp_valid              (rsp_valid),
   .rsp_new_first_vel_x    (rsp_new_first_vel_x),
   .rsp_coincident_centers (rsp_coincident_centers),
   .rsp_saturated          (rsp_saturated)
);
